// ----- rtl/sart_pkg.sv -----
package sart_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned AckW = 64;

  // Row layout in the entry memory: {valid, site, newest ack}
  localparam int unsigned RowW = 1 + KeyW + AckW;

  typedef logic [1:0] req_t;
  typedef logic [2:0] status_t;

  localparam req_t ReqCheck  = 2'd0;
  localparam req_t ReqUpdate = 2'd1;
  localparam req_t ReqInsert = 2'd2;
  localparam req_t ReqRemove = 2'd3;

  localparam status_t StOk        = 3'd0;
  localparam status_t StAdjust    = 3'd1;
  localparam status_t StIgnore    = 3'd2;
  localparam status_t StHoldWait  = 3'd3;
  localparam status_t StExists    = 3'd4;
  localparam status_t StNotFound  = 3'd5;
  localparam status_t StTableFull = 3'd6;

endpackage

// ----- rtl/sart_ram.sv -----
module sart_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/site_ack_replay_table_top.sv -----
// Channel | Direction | Handshake                   | Payload
// in      | input     | in_valid_i / in_ready_o     | req_type_i, site_id_i, ack_i, line_id_i
// out     | output    | out_valid_o / out_ready_i   | status_o, stored_ack_o, was_hit_o
//
// An item is accepted, then goes through a key scan of every entry (one memory read a cycle),
// a drain of the registered read, and a step applying the operation before the next is taken.
// The scan always covers the whole table; the single memory read port sets the pace.
// After reset a clearing pass over every entry zeroes the valid bits, ready low.
// A waiting result holds the next item in its final step until the output register frees.
module site_ack_replay_table_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [sart_pkg::KeyW-1:0]  site_id_i,
  input  logic [sart_pkg::AckW-1:0]  ack_i,
  input  logic [sart_pkg::AckW-1:0]  line_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [sart_pkg::AckW-1:0]  stored_ack_o,
  output logic                       was_hit_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] StateClear = 3'd0;
  localparam logic [2:0] StateIdle  = 3'd1;
  localparam logic [2:0] StateScan  = 3'd2;
  localparam logic [2:0] StateDrain = 3'd3;
  localparam logic [2:0] StateExec  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;

  sart_pkg::req_t            req_q;
  logic [sart_pkg::KeyW-1:0] key_q;
  logic [sart_pkg::AckW-1:0] ack_q, line_q;

  logic                      hit_q, hit_d;
  logic [AW-1:0]             hit_idx_q, hit_idx_d;
  logic [sart_pkg::AckW-1:0] hit_ack_q, hit_ack_d;
  logic                      free_q, free_d;
  logic [AW-1:0]             free_idx_q, free_idx_d;

  logic                      out_valid_q, out_valid_d;
  sart_pkg::status_t         status_q, res_status;
  logic [sart_pkg::AckW-1:0] stored_q, res_stored;
  logic                      was_hit_q;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [sart_pkg::RowW-1:0] wdata;
  logic [sart_pkg::RowW-1:0] rdata;

  logic                      in_acc;
  logic                      exec_go;
  logic                      row_valid;
  logic [sart_pkg::KeyW-1:0] row_site;
  logic [sart_pkg::AckW-1:0] row_ack;
  logic [sart_pkg::AckW-1:0] last_sel, new_last;
  logic                      ack_gt, ack_eq, line_le;
  logic                      row_wr;

  sart_ram #(
    .Width (sart_pkg::RowW),
    .Depth (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign row_valid = rdata[sart_pkg::RowW-1];
  assign row_site  = rdata[sart_pkg::RowW-2 -: sart_pkg::KeyW];
  assign row_ack   = rdata[sart_pkg::AckW-1:0];

  assign in_ready_o = (state_q == StateIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign exec_go    = !out_valid_q || out_ready_i;

  // Shared compare unit for the final step; on a miss the new entry holds ack.
  assign last_sel = hit_q ? hit_ack_q : ack_q;
  assign ack_gt   = ack_q > last_sel;
  assign ack_eq   = ack_q == last_sel;
  assign line_le  = line_q <= last_sel;

  // Scan bookkeeping: keep the lowest matching entry and the lowest free slot.
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_ack_d  = hit_ack_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (in_acc) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (rd_vld_q) begin
      if (row_valid && (row_site == key_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_q;
        hit_ack_d = row_ack;
      end
      if (!row_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  // Apply the operation on the scan outcome.
  always_comb begin
    res_status = sart_pkg::StOk;
    res_stored = '0;
    row_wr     = 1'b0;
    new_last   = last_sel;
    waddr      = hit_q ? hit_idx_q : free_idx_q;
    wdata      = '0;
    if (req_q == sart_pkg::ReqRemove) begin
      if (hit_q) begin
        res_stored = hit_ack_q;
        row_wr     = 1'b1;
      end else begin
        res_status = sart_pkg::StNotFound;
      end
    end else if ((req_q == sart_pkg::ReqInsert) && hit_q) begin
      res_status = sart_pkg::StExists;
      res_stored = hit_ack_q;
    end else if (!hit_q && !free_q) begin
      res_status = sart_pkg::StTableFull;
    end else begin
      row_wr = !hit_q;
      if ((req_q == sart_pkg::ReqUpdate) && hit_q && ack_gt) begin
        new_last = ack_q;
        row_wr   = 1'b1;
      end
      if (req_q == sart_pkg::ReqCheck) begin
        if (ack_q == '0) begin
          res_status = sart_pkg::StAdjust;
        end else if (ack_eq) begin
          res_status = line_le ? sart_pkg::StIgnore : sart_pkg::StOk;
        end else if (!ack_gt) begin
          res_status = line_le ? sart_pkg::StAdjust : sart_pkg::StHoldWait;
        end else begin
          new_last = ack_q;
          row_wr   = 1'b1;
        end
      end
      res_stored = new_last;
      wdata      = {1'b1, key_q, new_last};
    end
    if (state_q == StateClear) begin
      waddr = addr_q;
      wdata = '0;
    end
  end

  assign we = (state_q == StateClear) || ((state_q == StateExec) && exec_go && row_wr);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StateClear: begin
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = StateIdle;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      StateIdle: begin
        if (in_acc) begin
          addr_d  = '0;
          state_d = StateScan;
        end
      end
      StateScan: begin
        rd_vld_d = 1'b1;
        if (addr_q == LastIdx) begin
          state_d = StateDrain;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      StateDrain: begin
        state_d = StateExec;
      end
      StateExec: begin
        if (exec_go) begin
          out_valid_d = 1'b1;
          state_d     = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= addr_q;
    hit_idx_q  <= hit_idx_d;
    hit_ack_q  <= hit_ack_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      req_q  <= req_type_i;
      key_q  <= site_id_i;
      ack_q  <= ack_i;
      line_q <= line_id_i;
    end
    if ((state_q == StateExec) && exec_go) begin
      status_q  <= res_status;
      stored_q  <= res_stored;
      was_hit_q <= hit_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign stored_ack_o = stored_q;
  assign was_hit_o    = was_hit_q;

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == StateClear) || (state_q == StateExec))
    else $error("entry memory written outside clear or exec");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StateExec)
    else $error("result raised without an exec step");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StateScan) && (addr_q == '0))
    else $error("accepted item did not start a scan");

  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == sart_pkg::StTableFull)) |-> !was_hit_o && (stored_ack_o == '0))
    else $error("table full result carries a hit or a value");

  a_exec_no_write_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StateExec) && !exec_go) |=> (state_q == StateExec) && !$past(we))
    else $error("stalled exec step wrote the table or advanced");

endmodule
